@@ rtl/apn_pkg.sv @@
// Shared types, constants and rounding helpers for the allpass peak/notch filter.
// No dependencies; used by apn_dp and allpass_peak_notch_filter_core.
package apn_pkg;

  localparam int SampleW  = 24;
  localparam int StateW   = SampleW + 4;
  localparam int CoefW    = 24;
  localparam int CoefFrac = 22;
  localparam int GainFrac = 20;
  localparam int KW       = 26;
  localparam int MulAW    = 26;
  localparam int MulBW    = StateW + 1;
  localparam int ProdW    = MulAW + MulBW;
  localparam int AccW     = ProdW + 1;
  localparam int CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] RegCoefCenter    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCoefBandwidth = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMixGain       = 2'd2;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_in;
    logic                      chan;
  } in_req_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic                      chan_out;
  } out_req_t;

  typedef enum logic [2:0] {
    MUL_D_OMC,
    MUL_K_H1,
    MUL_C_H2,
    MUL_C_XH,
    MUL_G_DIFF
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_SUB_P,
    ACC_ADD_P,
    ACC_LOAD_H2K
  } acc_op_e;

  typedef struct packed {
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     k_we;
    logic     kh1_we;
    logic     xh_we;
    logic     y1_we;
    logic     diff_we;
  } dp_ctrl_t;

  // round half up by CoefFrac bits, saturate to the state width
  function automatic logic signed [StateW-1:0] round_sat_state(
      input logic signed [AccW-1:0] v);
    logic [AccW-1:0]          t;
    logic [AccW-CoefFrac-1:0] s;
    logic [StateW-1:0]        r;
    t = v + (AccW'(1) << (CoefFrac - 1));
    s = t[AccW-1:CoefFrac];
    if ((&s[AccW-CoefFrac-1:StateW-1]) || !(|s[AccW-CoefFrac-1:StateW-1])) begin
      r = s[StateW-1:0];
    end else if (s[AccW-CoefFrac-1]) begin
      r = {1'b1, {(StateW-1){1'b0}}};
    end else begin
      r = {1'b0, {(StateW-1){1'b1}}};
    end
    return r;
  endfunction

  // round half up by GainFrac bits, saturate to the sample width
  function automatic logic signed [SampleW-1:0] round_sat_out(
      input logic signed [AccW-1:0] v);
    logic [AccW-1:0]          t;
    logic [AccW-GainFrac-1:0] s;
    logic [SampleW-1:0]       r;
    t = v + (AccW'(1) << (GainFrac - 1));
    s = t[AccW-1:GainFrac];
    if ((&s[AccW-GainFrac-1:SampleW-1]) || !(|s[AccW-GainFrac-1:SampleW-1])) begin
      r = s[SampleW-1:0];
    end else if (s[AccW-GainFrac-1]) begin
      r = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      r = {1'b0, {(SampleW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ rtl/allpass_peak_notch_filter_core.sv @@
// Top level of the allpass peak/notch equalizer: config registers, sequencer,
// per-channel state RAM and output register. Depends on apn_pkg, apn_ram, apn_dp.
//
// Second-order allpass peak/notch section for interleaved audio channels.
// An accepted sample is finished before the block is ready for the next one:
// the five products of the filter go one after another through a single
// shared 26x29 multiplier, each followed by its accumulate and round/saturate
// steps, and the channel state (two delay values) is read from and written
// back to one RAM entry per channel. The result sits in an output register,
// so a new sample is taken while the previous result still waits; the
// sequencer holds its last step only when that register is still full.
// Channel state resets to zero through per-entry valid bits, so there is no
// clearing pass. Coefficients are to be written by the user only while the
// block is idle; the block itself does not enforce it.
module allpass_peak_notch_filter_core #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [apn_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [apn_pkg::CoefW-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  apn_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output apn_pkg::out_req_t               out_req_o
);

  localparam int AddrW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int StW   = apn_pkg::StateW;
  localparam int CW    = apn_pkg::CoefW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_K,
    ST_KH1,
    ST_CH2,
    ST_XH,
    ST_XHS,
    ST_CXH,
    ST_Y1A,
    ST_Y1S,
    ST_DIFF,
    ST_G,
    ST_OUT
  } state_e;

  state_e                             state_q;
  logic [CW-1:0]                      coef_center_q;
  logic [CW-1:0]                      coef_bandwidth_q;
  logic [CW-1:0]                      mix_gain_q;
  logic                               out_valid_q;
  apn_pkg::out_req_t                  out_q;
  logic [NUM_CHANNELS-1:0]            valid_q;
  logic                               rd_valid_q;
  logic signed [apn_pkg::SampleW-1:0] x_q;
  logic                               chan_q;

  logic                               in_acc;
  logic                               out_free;
  logic                               wb;
  logic [AddrW-1:0]                   raddr;
  logic [AddrW-1:0]                   waddr;
  logic [2*StW-1:0]                   rdata;
  logic signed [StW-1:0]              h1;
  logic signed [StW-1:0]              h2;
  logic signed [StW-1:0]              xh;
  logic signed [apn_pkg::SampleW-1:0] y;
  apn_pkg::dp_ctrl_t                  ctrl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign wb         = (state_q == ST_OUT) && out_free;

  // chan is one bit, so modulo the channel count only matters for one channel
  assign raddr = (NUM_CHANNELS > 1) ? AddrW'(in_req_i.chan) : '0;
  assign waddr = (NUM_CHANNELS > 1) ? AddrW'(chan_q) : '0;

  // never-written entries read as zero state
  assign h1 = rd_valid_q ? rdata[2*StW-1:StW] : '0;
  assign h2 = rd_valid_q ? rdata[StW-1:0] : '0;

  always_comb begin
    ctrl         = '0;
    ctrl.mul_sel = apn_pkg::MUL_D_OMC;
    ctrl.acc_op  = apn_pkg::ACC_HOLD;
    case (state_q)
      ST_RD:   ctrl.mul_en = 1'b1;
      ST_K:    ctrl.k_we = 1'b1;
      ST_KH1: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = apn_pkg::MUL_K_H1;
        ctrl.acc_op  = apn_pkg::ACC_LOAD_X;
      end
      ST_CH2: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = apn_pkg::MUL_C_H2;
        ctrl.acc_op  = apn_pkg::ACC_SUB_P;
        ctrl.kh1_we  = 1'b1;
      end
      ST_XH:   ctrl.acc_op = apn_pkg::ACC_ADD_P;
      ST_XHS:  ctrl.xh_we = 1'b1;
      ST_CXH: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = apn_pkg::MUL_C_XH;
        ctrl.acc_op  = apn_pkg::ACC_LOAD_H2K;
      end
      ST_Y1A:  ctrl.acc_op = apn_pkg::ACC_SUB_P;
      ST_Y1S:  ctrl.y1_we = 1'b1;
      ST_DIFF: ctrl.diff_we = 1'b1;
      ST_G: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = apn_pkg::MUL_G_DIFF;
      end
      default: ctrl = ctrl;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      coef_center_q    <= '0;
      coef_bandwidth_q <= '0;
      mix_gain_q       <= '0;
      out_valid_q      <= 1'b0;
      valid_q          <= '0;
      rd_valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          apn_pkg::RegCoefCenter:    coef_center_q    <= cfg_wdata_i;
          apn_pkg::RegCoefBandwidth: coef_bandwidth_q <= cfg_wdata_i;
          apn_pkg::RegMixGain:       mix_gain_q       <= cfg_wdata_i;
          default:                   coef_center_q    <= coef_center_q;
        endcase
      end
      if (wb) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        rd_valid_q <= valid_q[raddr];
      end
      case (state_q)
        ST_IDLE: if (in_acc) state_q <= ST_RD;
        ST_RD:   state_q <= ST_K;
        ST_K:    state_q <= ST_KH1;
        ST_KH1:  state_q <= ST_CH2;
        ST_CH2:  state_q <= ST_XH;
        ST_XH:   state_q <= ST_XHS;
        ST_XHS:  state_q <= ST_CXH;
        ST_CXH:  state_q <= ST_Y1A;
        ST_Y1A:  state_q <= ST_Y1S;
        ST_Y1S:  state_q <= ST_DIFF;
        ST_DIFF: state_q <= ST_G;
        ST_G:    state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            valid_q[waddr] <= 1'b1;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= in_req_i.sample_in;
      chan_q <= in_req_i.chan;
    end
    if (wb) begin
      out_q.sample_out <= y;
      out_q.chan_out   <= chan_q;
    end
  end

  // write-back lands before the next read can be issued, so no forwarding
  apn_ram #(
    .Width (2 * StW),
    .Depth (NUM_CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wb),
    .waddr_i (waddr),
    .wdata_i ({xh, h1}),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  apn_dp u_dp (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .x_i      (x_q),
    .coef_d_i (coef_center_q),
    .coef_c_i (coef_bandwidth_q),
    .gain_i   (mix_gain_q),
    .h1_i     (h1),
    .h2_i     (h2),
    .xh_o     (xh),
    .y_o      (y)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

@@ rtl/apn_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module apn_ram #(
  parameter int Width = 8,
  parameter int Depth = 2,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/apn_dp.sv @@
// Filter datapath: one shared signed multiplier, accumulator, rounding/saturation.
// Depends on apn_pkg; sequenced by the control struct from the core FSM.
module apn_dp (
  input  logic                               clk_i,
  input  apn_pkg::dp_ctrl_t                  ctrl_i,
  input  logic signed [apn_pkg::SampleW-1:0] x_i,
  input  logic signed [apn_pkg::CoefW-1:0]   coef_d_i,
  input  logic signed [apn_pkg::CoefW-1:0]   coef_c_i,
  input  logic signed [apn_pkg::CoefW-1:0]   gain_i,
  input  logic signed [apn_pkg::StateW-1:0]  h1_i,
  input  logic signed [apn_pkg::StateW-1:0]  h2_i,
  output logic signed [apn_pkg::StateW-1:0]  xh_o,
  output logic signed [apn_pkg::SampleW-1:0] y_o
);

  localparam int AccW  = apn_pkg::AccW;
  localparam int ProdW = apn_pkg::ProdW;
  localparam int KW    = apn_pkg::KW;
  localparam int SW    = apn_pkg::SampleW;
  localparam int StW   = apn_pkg::StateW;
  localparam int CW    = apn_pkg::CoefW;
  localparam int CF    = apn_pkg::CoefFrac;
  localparam int GF    = apn_pkg::GainFrac;

  logic signed [ProdW-1:0]           prod_q, prod_d;
  logic signed [AccW-1:0]            acc_q, acc_d;
  logic signed [KW-1:0]              k_q;
  logic signed [ProdW-1:0]           kh1_q;
  logic signed [StW-1:0]             xh_q;
  logic signed [StW-1:0]             y1_q;
  logic signed [apn_pkg::MulBW-1:0]  diff_q;
  logic signed [apn_pkg::MulAW-1:0]  mul_a;
  logic signed [apn_pkg::MulBW-1:0]  mul_b;
  logic signed [KW-1:0]              omc;
  logic [ProdW-1:0]                  k_rnd;
  logic signed [AccW-1:0]            prod_ext;
  logic signed [AccW-1:0]            y_acc;

  // 1 - c is exact in 26 bits
  assign omc = (KW'(1) << CF) - {{(KW-CW){coef_c_i[CW-1]}}, coef_c_i};

  always_comb begin
    case (ctrl_i.mul_sel)
      apn_pkg::MUL_D_OMC: begin
        mul_a = {{(KW-CW){coef_d_i[CW-1]}}, coef_d_i};
        mul_b = {{(apn_pkg::MulBW-KW){omc[KW-1]}}, omc};
      end
      apn_pkg::MUL_K_H1: begin
        mul_a = k_q;
        mul_b = {h1_i[StW-1], h1_i};
      end
      apn_pkg::MUL_C_H2: begin
        mul_a = {{(KW-CW){coef_c_i[CW-1]}}, coef_c_i};
        mul_b = {h2_i[StW-1], h2_i};
      end
      apn_pkg::MUL_C_XH: begin
        mul_a = {{(KW-CW){coef_c_i[CW-1]}}, coef_c_i};
        mul_b = {xh_q[StW-1], xh_q};
      end
      apn_pkg::MUL_G_DIFF: begin
        mul_a = {{(KW-CW){gain_i[CW-1]}}, gain_i};
        mul_b = diff_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = {prod_q[ProdW-1], prod_q};

  always_comb begin
    case (ctrl_i.acc_op)
      apn_pkg::ACC_LOAD_X:   acc_d = {{(AccW-SW-CF){x_i[SW-1]}}, x_i, {CF{1'b0}}};
      apn_pkg::ACC_SUB_P:    acc_d = acc_q - prod_ext;
      apn_pkg::ACC_ADD_P:    acc_d = acc_q + prod_ext;
      apn_pkg::ACC_LOAD_H2K: acc_d = {{(AccW-StW-CF){h2_i[StW-1]}}, h2_i, {CF{1'b0}}}
                                     + {kh1_q[ProdW-1], kh1_q};
      apn_pkg::ACC_HOLD:     acc_d = acc_q;
      default:               acc_d = acc_q;
    endcase
  end

  // k = d*(1-c) rounded to Q.22, fits in 26 bits
  assign k_rnd = prod_q + (ProdW'(1) << (CF - 1));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
    if (ctrl_i.k_we) begin
      k_q <= k_rnd[CF+KW-1:CF];
    end
    if (ctrl_i.kh1_we) begin
      kh1_q <= prod_q;
    end
    if (ctrl_i.xh_we) begin
      xh_q <= apn_pkg::round_sat_state(acc_q);
    end
    if (ctrl_i.y1_we) begin
      y1_q <= apn_pkg::round_sat_state(acc_q);
    end
    if (ctrl_i.diff_we) begin
      diff_q <= {x_i[SW-1], {(StW-SW){x_i[SW-1]}}, x_i} - {y1_q[StW-1], y1_q};
    end
  end

  // y = x + round(g*(x - y1)); x is aligned to the product's fraction first
  assign y_acc = prod_ext + {{(AccW-SW-GF){x_i[SW-1]}}, x_i, {GF{1'b0}}};
  assign y_o   = apn_pkg::round_sat_out(y_acc);
  assign xh_o  = xh_q;

endmodule
